FILE: src/ptb_pkg.sv
`timescale 1ns / 1ps

package ptb_pkg;

  // item opcodes, carried on the slave-side tuser
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_TAKE  = 3'd3,
    OP_QUERY = 3'd4
  } op_e;

  // field widths
  localparam int OP_W     = 3;
  localparam int IDX_W    = 8;
  localparam int IVL_W    = 24;
  localparam int TOTAL_W  = 32;

  // stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

endpackage

FILE: src/ptb_timer_mem.sv
`timescale 1ns / 1ps

// timer entry store: one write and one registered read per cycle,
// with a valid bit per entry so unwritten entries read as zero
module ptb_timer_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 49,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_vld_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  // never-written entries read as the reset value
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: src/periodic_timer_bank.sv
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                                   tuser
// s_axis    in   timer_index[7:0], interval_ticks[31:8]               opcode[2:0]
// m_axis    out  index_ok[0], expired_flag[1], stopped_flag[2],       -
//                running_flag[3], tick_total[35:4], zero pad[39:36]
//
// one item at a time; start/stop/take/query step through read, modify-write
// and emit on the way to the output register; a tick steps through accept,
// one sweep cycle per timer entry through the one read port of the
// entry memory, last write-back and emit; an index outside the bank or an
// unused opcode steps through accept and emit only.
// reset clears the entry valid bits, so no clearing pass is needed.
// a result waiting in the output register does not block the next accept;
// the emit step waits for the output register to drain.
module periodic_timer_bank #(
  parameter int NUM_TIMERS  = 16,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ptb_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // timer_index, interval_ticks
  input  logic [ptb_pkg::OP_W-1:0]       s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // index_ok, expired_flag, stopped_flag, running_flag, tick_total, pad
  output logic [ptb_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam int EW = 2 * CW + 1;
  localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;
  localparam int PAD_W = ptb_pkg::M_TDATA_W - ptb_pkg::TOTAL_W - 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  ptb_pkg::op_e                op_q;
  logic [IW-1:0]               idx_q;
  logic [CW-1:0]               ivl_q;
  logic [IW-1:0]               cnt_q;
  logic                        pend_q;
  logic [IW-1:0]               pend_addr_q;
  logic [ptb_pkg::TOTAL_W-1:0] ticks_q;
  logic                        res_exp_q, res_stp_q, res_run_q, res_ok_q;
  logic                        m_valid_q;
  logic [ptb_pkg::M_TDATA_W-1:0] m_data_q;

  logic                        s_beat;
  logic [ptb_pkg::IDX_W-1:0]   in_idx;
  logic [31:0]                 ivl_w;
  logic [CW-1:0]               ivl_sat;
  logic                        in_ok;

  logic [IW-1:0]               rd_addr;
  logic [EW-1:0]               rd_data;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [EW-1:0]               wr_data;

  logic [CW-1:0]               ent_rem, ent_rel;
  logic                        ent_lat;
  logic [CW-1:0]               new_rem, new_rel;
  logic                        new_lat;
  logic                        op_exp, op_stp, op_run;

  // input beat decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[ptb_pkg::IDX_W-1:0];
  assign in_ok         = ({1'b0, in_idx} < 9'(NUM_TIMERS));

  // start interval: zero raised to one, saturated to the counter width
  always_comb begin
    ivl_w = {8'b0, s_axis_tdata[ptb_pkg::IDX_W +: ptb_pkg::IVL_W]};
    if (ivl_w == 32'd0) begin
      ivl_w = 32'd1;
    end
    if ({1'b0, ivl_w} > CNT_MAX) begin
      ivl_w = CNT_MAX[31:0];
    end
    ivl_sat = ivl_w[CW-1:0];
  end

  // read address: the addressed timer on accept, the sweep counter on a tick
  assign rd_addr = (state_q == ST_SWEEP) ? cnt_q : in_idx[IW-1:0];

  // entry fields: remaining low, reload above it, expiry latch on top
  assign ent_rem = rd_data[CW-1:0];
  assign ent_rel = rd_data[2*CW-1:CW];
  assign ent_lat = rd_data[2*CW];

  // read-modify-write of one entry
  always_comb begin
    new_rem = ent_rem;
    new_rel = ent_rel;
    new_lat = ent_lat;
    op_exp  = 1'b0;
    op_stp  = 1'b0;
    op_run  = 1'b0;
    if (pend_q) begin
      // tick on one entry of the sweep
      if (ent_rel != '0) begin
        if (ent_rem <= CW'(1)) begin
          new_rem = ent_rel;
          new_lat = 1'b1;
        end else begin
          new_rem = ent_rem - CW'(1);
        end
      end
    end else begin
      case (op_q)
        ptb_pkg::OP_START: begin
          new_rem = ivl_q;
          new_rel = ivl_q;
          new_lat = 1'b0;
        end
        ptb_pkg::OP_STOP: begin
          new_rel = '0;
        end
        ptb_pkg::OP_TAKE: begin
          op_exp  = ent_lat;
          new_lat = 1'b0;
        end
        ptb_pkg::OP_QUERY: begin
          op_stp = (ent_rel == '0);
          op_run = (ent_rel != '0) && !ent_lat;
        end
        default: begin
        end
      endcase
    end
  end

  // write port: sweep entries and single-timer updates never overlap
  assign wr_en   = pend_q || (state_q == ST_MODIFY);
  assign wr_addr = pend_q ? pend_addr_q : idx_q;
  assign wr_data = {new_lat, new_rel, new_rem};

  ptb_timer_mem #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer, tick count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ptb_pkg::OP_TICK;
      idx_q       <= '0;
      ivl_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      ticks_q     <= '0;
      res_exp_q   <= 1'b0;
      res_stp_q   <= 1'b0;
      res_run_q   <= 1'b0;
      res_ok_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // a sweep read is written back in the cycle after it
      pend_q <= (state_q == ST_SWEEP);
      if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_beat) begin
            op_q      <= ptb_pkg::op_e'(s_axis_tuser);
            idx_q     <= in_idx[IW-1:0];
            ivl_q     <= ivl_sat;
            res_exp_q <= 1'b0;
            res_stp_q <= 1'b0;
            res_run_q <= 1'b0;
            cnt_q     <= '0;
            if (s_axis_tuser == ptb_pkg::OP_TICK) begin
              ticks_q  <= ticks_q + 32'd1;
              res_ok_q <= 1'b0;
              state_q  <= ST_SWEEP;
            end else if (s_axis_tuser <= ptb_pkg::OP_QUERY && in_ok) begin
              res_ok_q <= 1'b1;
              state_q  <= ST_MODIFY;
            end else begin
              res_ok_q <= 1'b0;
              state_q  <= ST_EMIT;
            end
          end
        end
        ST_MODIFY: begin
          res_exp_q <= op_exp;
          res_stp_q <= op_stp;
          res_run_q <= op_run;
          state_q   <= ST_EMIT;
        end
        ST_SWEEP: begin
          pend_addr_q <= cnt_q;
          cnt_q       <= cnt_q + IW'(1);
          if (cnt_q == IW'(NUM_TIMERS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last sweep entry is written back in this cycle
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {{PAD_W{1'b0}}, ticks_q, res_run_q, res_stp_q,
                          res_exp_q, res_ok_q};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: src/ptb_checker.sv
`timescale 1ns / 1ps

module ptb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ptb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [ptb_pkg::TOTAL_W-1:0] last_total_q;
  logic [ptb_pkg::TOTAL_W-1:0] total;
  logic                        ok, exp_f, stp_f, run_f;

  assign ok    = m_axis_tdata[0];
  assign exp_f = m_axis_tdata[1];
  assign stp_f = m_axis_tdata[2];
  assign run_f = m_axis_tdata[3];
  assign total = m_axis_tdata[4 +: ptb_pkg::TOTAL_W];

  // tick count of the last output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_total_q <= total;
    end
  end

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // tick count moves by at most one tick per item
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |->
      (total == last_total_q) || (total == last_total_q + 32'd1))
    else $error("tick count jumped between beats");

  // flags come from a single valid timer operation
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(stp_f && run_f) && !(exp_f && (stp_f || run_f)) &&
      !((exp_f || stp_f || run_f) && !ok))
    else $error("inconsistent result flags");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
